// ===== rtl/ipag_pkg.sv =====
package ipag_pkg;

	localparam int COORD_W = 14;
	localparam int ADDR_W  = 32;
	localparam int TAP_W   = 6;

	// APB register map, one 32-bit word per register
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_STRIDE_ROWS   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_STRIDE_COLS   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DILATION_ROWS = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DILATION_COLS = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PAD_TOP       = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_PAD_LEFT      = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT     = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH      = 3'd7;

	// position queue between front and back
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W      = 3;
	localparam int QCNT_W      = 4;

	typedef struct packed {
		logic [4:0]  stride_rows;
		logic [4:0]  stride_cols;
		logic [4:0]  dilation_rows;
		logic [4:0]  dilation_cols;
		logic [7:0]  pad_top;
		logic [7:0]  pad_left;
		logic [12:0] in_height;
		logic [12:0] in_width;
	} cfg_t;

	// one output position, reduced to tap-0 coordinates plus per-tap increments
	typedef struct packed {
		logic signed [COORD_W-1:0] row0;
		logic signed [COORD_W-1:0] col0;
		logic [ADDR_W-1:0]         row_acc0;   // src batch base + row0*W*BLOCK
		logic [ADDR_W-1:0]         row_step;   // dilation_rows*W*BLOCK
		logic [ADDR_W-1:0]         col_acc0;   // col0*BLOCK
		logic [ADDR_W-1:0]         col_step;   // dilation_cols*BLOCK
		logic [ADDR_W-1:0]         dst_base;
	} pos_t;

endpackage

// ===== rtl/ipag_cfg_regs.sv =====
module ipag_cfg_regs
	import ipag_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;
	cfg_t                 cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[PADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stride_rows   <= 5'd1;
			cfg_q.stride_cols   <= 5'd1;
			cfg_q.dilation_rows <= 5'd1;
			cfg_q.dilation_cols <= 5'd1;
			cfg_q.pad_top       <= 8'd0;
			cfg_q.pad_left      <= 8'd0;
			cfg_q.in_height     <= 13'd64;
			cfg_q.in_width      <= 13'd64;
		end else if (wr_en) begin
			unique case (idx)
				REG_STRIDE_ROWS:   cfg_q.stride_rows   <= pwdata[4:0];
				REG_STRIDE_COLS:   cfg_q.stride_cols   <= pwdata[4:0];
				REG_DILATION_ROWS: cfg_q.dilation_rows <= pwdata[4:0];
				REG_DILATION_COLS: cfg_q.dilation_cols <= pwdata[4:0];
				REG_PAD_TOP:       cfg_q.pad_top       <= pwdata[7:0];
				REG_PAD_LEFT:      cfg_q.pad_left      <= pwdata[7:0];
				REG_IN_HEIGHT:     cfg_q.in_height     <= pwdata[12:0];
				REG_IN_WIDTH:      cfg_q.in_width      <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_STRIDE_ROWS:   prdata = PDATA_W'(cfg_q.stride_rows);
			REG_STRIDE_COLS:   prdata = PDATA_W'(cfg_q.stride_cols);
			REG_DILATION_ROWS: prdata = PDATA_W'(cfg_q.dilation_rows);
			REG_DILATION_COLS: prdata = PDATA_W'(cfg_q.dilation_cols);
			REG_PAD_TOP:       prdata = PDATA_W'(cfg_q.pad_top);
			REG_PAD_LEFT:      prdata = PDATA_W'(cfg_q.pad_left);
			REG_IN_HEIGHT:     prdata = PDATA_W'(cfg_q.in_height);
			REG_IN_WIDTH:      prdata = PDATA_W'(cfg_q.in_width);
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== rtl/ipag_front.sv =====
module ipag_front
	import ipag_pkg::*;
#(
	parameter int KERNEL_H  = 3,
	parameter int KERNEL_W  = 3,
	parameter int CH_BLOCKS = 8,
	parameter int BLOCK     = 8,
	parameter int OUT_H     = 64,
	parameter int OUT_W     = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [3:0]        batch_index,
	input  logic [5:0]        out_row,
	input  logic [5:0]        out_col,
	input  logic [QCNT_W-1:0] q_count,
	output logic              q_push,
	output pos_t              q_data
);

	localparam int CHANS = CH_BLOCKS * BLOCK;
	localparam int BC_W  = 4 + $clog2(CHANS + 1);
	localparam int WB_W  = 13 + $clog2(BLOCK + 1);
	localparam logic [63:0] DST_B_64 =
		64'(KERNEL_H) * 64'(KERNEL_W) * 64'(CHANS) * 64'(OUT_H) * 64'(OUT_W);
	localparam logic [63:0] DST_ROW_64 = 64'(OUT_W) * 64'(BLOCK);
	localparam logic [ADDR_W-1:0] DST_B_STRIDE   = DST_B_64[ADDR_W-1:0];
	localparam logic [ADDR_W-1:0] DST_ROW_STRIDE = DST_ROW_64[ADDR_W-1:0];
	localparam logic [ADDR_W-1:0] BLOCK_A        = ADDR_W'(BLOCK);

	logic in_fire;
	logic v_s1, v_s2, v_s3;
	logic [QCNT_W:0] occupancy;

	// stage 1
	logic [BC_W-1:0]           bc_s1;
	logic [25:0]               hw_s1;
	logic [WB_W-1:0]           wb_s1;
	logic signed [COORD_W-1:0] row0_s1, col0_s1;
	logic [ADDR_W-1:0]         dst_s1, cstep_s1;
	// stage 2
	logic [ADDR_W-1:0]         sbase_s2, rowa_s2, rstep_s2, cola_s2, dst_s2, cstep_s2;
	logic signed [COORD_W-1:0] row0_s2, col0_s2;
	// stage 3
	pos_t                      pos_s3;

	// credit: everything in flight must fit the queue
	assign occupancy = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(v_s1) + (QCNT_W+1)'(v_s2)
		+ (QCNT_W+1)'(v_s3);
	assign in_ready  = occupancy < (QCNT_W+1)'(QUEUE_DEPTH);
	assign in_fire   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		bc_s1    <= BC_W'(batch_index) * BC_W'(CHANS);
		hw_s1    <= 26'(cfg.in_height) * 26'(cfg.in_width);
		wb_s1    <= WB_W'(cfg.in_width) * WB_W'(BLOCK);
		row0_s1  <= {3'b000, 11'(out_row) * 11'(cfg.stride_rows)} - {6'd0, cfg.pad_top};
		col0_s1  <= {3'b000, 11'(out_col) * 11'(cfg.stride_cols)} - {6'd0, cfg.pad_left};
		dst_s1   <= ADDR_W'(batch_index) * DST_B_STRIDE + ADDR_W'(out_row) * DST_ROW_STRIDE
			+ ADDR_W'(out_col) * BLOCK_A;
		cstep_s1 <= ADDR_W'(cfg.dilation_cols) * BLOCK_A;

		sbase_s2 <= ADDR_W'(bc_s1) * ADDR_W'(hw_s1);
		rowa_s2  <= ADDR_W'(row0_s1) * ADDR_W'(wb_s1);
		rstep_s2 <= ADDR_W'(cfg.dilation_rows) * ADDR_W'(wb_s1);
		cola_s2  <= ADDR_W'(col0_s1) * BLOCK_A;
		dst_s2   <= dst_s1;
		cstep_s2 <= cstep_s1;
		row0_s2  <= row0_s1;
		col0_s2  <= col0_s1;

		pos_s3.row0     <= row0_s2;
		pos_s3.col0     <= col0_s2;
		pos_s3.row_acc0 <= sbase_s2 + rowa_s2;
		pos_s3.row_step <= rstep_s2;
		pos_s3.col_acc0 <= cola_s2;
		pos_s3.col_step <= cstep_s2;
		pos_s3.dst_base <= dst_s2;
	end

	assign q_push = v_s3;
	assign q_data = pos_s3;

endmodule

// ===== rtl/ipag_queue.sv =====
module ipag_queue
	import ipag_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pos_t              wr_data,
	input  logic              pop,
	output pos_t              rd_data,
	output logic [QCNT_W-1:0] count
);

	pos_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign rd_data = mem_q[rd_ptr_q];
	assign count   = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (!push && pop) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ===== rtl/ipag_back.sv =====
module ipag_back
	import ipag_pkg::*;
#(
	parameter int KERNEL_H  = 3,
	parameter int KERNEL_W  = 3,
	parameter int CH_BLOCKS = 8,
	parameter int BLOCK     = 8,
	parameter int OUT_H     = 64,
	parameter int OUT_W     = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic [QCNT_W-1:0]         q_count,
	input  pos_t                      q_data,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] src_row,
	output logic signed [COORD_W-1:0] src_col,
	output logic                      is_padding,
	output logic [ADDR_W-1:0]         src_addr,
	output logic [ADDR_W-1:0]         dst_addr,
	output logic [TAP_W-1:0]          tap_index,
	output logic                      last_tap
);

	localparam int KH_W = (KERNEL_H > 1) ? $clog2(KERNEL_H) : 1;
	localparam int KW_W = (KERNEL_W > 1) ? $clog2(KERNEL_W) : 1;
	localparam logic [KH_W-1:0] KH_LAST = KH_W'(KERNEL_H - 1);
	localparam logic [KW_W-1:0] KW_LAST = KW_W'(KERNEL_W - 1);
	localparam logic [63:0] TAP_STRIDE_64 =
		64'(CH_BLOCKS) * 64'(BLOCK) * 64'(OUT_H) * 64'(OUT_W);
	localparam logic [ADDR_W-1:0] TAP_STRIDE = TAP_STRIDE_64[ADDR_W-1:0];

	logic            busy_q, out_valid_q;
	logic [KH_W-1:0] kh_q;
	logic [KW_W-1:0] kw_q;
	logic [TAP_W-1:0] tap_q;

	logic signed [COORD_W-1:0] row_q, col_q, col0_q;
	logic [ADDR_W-1:0] row_acc_q, col_acc_q, col_acc0_q, row_step_q, col_step_q, dst_q;

	logic issue, last_kw, last, pad, q_nonempty;

	assign q_nonempty = q_count != '0;
	assign issue      = busy_q && (!out_valid_q || out_ready);
	assign last_kw    = kw_q == KW_LAST;
	assign last       = last_kw && (kh_q == KH_LAST);
	assign q_pop      = q_nonempty && (!busy_q || (issue && last));

	// outside the image when negative or at/after the size
	assign pad = row_q[COORD_W-1] || (row_q >= $signed({1'b0, cfg.in_height}))
		|| col_q[COORD_W-1] || (col_q >= $signed({1'b0, cfg.in_width}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			kh_q        <= '0;
			kw_q        <= '0;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				kh_q   <= '0;
				kw_q   <= '0;
				tap_q  <= '0;
			end else if (issue) begin
				if (last) busy_q <= 1'b0;
				tap_q <= tap_q + 1'b1;
				if (last_kw) begin
					kw_q <= '0;
					kh_q <= kh_q + 1'b1;
				end else begin
					kw_q <= kw_q + 1'b1;
				end
			end
			if (issue)          out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			row_q      <= q_data.row0;
			col_q      <= q_data.col0;
			col0_q     <= q_data.col0;
			row_acc_q  <= q_data.row_acc0;
			col_acc_q  <= q_data.col_acc0;
			col_acc0_q <= q_data.col_acc0;
			row_step_q <= q_data.row_step;
			col_step_q <= q_data.col_step;
			dst_q      <= q_data.dst_base;
		end else if (issue) begin
			dst_q <= dst_q + TAP_STRIDE;
			if (last_kw) begin
				col_q     <= col0_q;
				col_acc_q <= col_acc0_q;
				row_q     <= row_q + $signed({9'd0, cfg.dilation_rows});
				row_acc_q <= row_acc_q + row_step_q;
			end else begin
				col_q     <= col_q + $signed({9'd0, cfg.dilation_cols});
				col_acc_q <= col_acc_q + col_step_q;
			end
		end
		if (issue) begin
			src_row    <= row_q;
			src_col    <= col_q;
			is_padding <= pad;
			src_addr   <= pad ? '0 : row_acc_q + col_acc_q;
			dst_addr   <= dst_q;
			tap_index  <= tap_q;
			last_tap   <= last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/image_patch_address_generator.sv =====
// Image patch address generator (im2col with stride, dilation and padding).
// Input channel: in_valid/in_ready transfers one output position
//   (batch_index, out_row, out_col).
// Output channel: out_valid/out_ready; each position yields KERNEL_H*KERNEL_W
//   transfers, one per kernel tap in row-major order, last_tap set on the final
//   one. Each carries the tap's input coordinates, is_padding, the source address
//   of channel block 0 (0 for padding taps) and the destination address.
// Throughput: one tap per cycle while out_ready holds, set by the tap sequencer
//   in the back end. Positions follow each other with no gap between their tap
//   bursts when the next one already waits in the queue.
// Path of a position: the 3-stage front pipeline, the queue, the tap sequencer
//   registers in the back end, then the output register.
// A queue of 8 positions sits between front and back; the front takes new
//   positions while the back is busy or stalled, until queue and pipeline fill it.
// Receiver stall: the output register holds its tap; the sequencer waits.
// Reset (arst_n low): registers return to their defaults, the queue and all
//   pipelines empty. Config registers sit on an APB port at 4*index and may be
//   written only while the block is idle.
module image_patch_address_generator
	import ipag_pkg::*;
#(
	parameter int KERNEL_H  = 3,
	parameter int KERNEL_W  = 3,
	parameter int CH_BLOCKS = 8,
	parameter int BLOCK     = 8,
	parameter int OUT_H     = 64,
	parameter int OUT_W     = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// config
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [PDATA_W-1:0]        pwdata,
	output logic [PDATA_W-1:0]        prdata,
	output logic                      pready,
	// positions
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [3:0]                batch_index,
	input  logic [5:0]                out_row,
	input  logic [5:0]                out_col,
	// taps
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] src_row,
	output logic signed [COORD_W-1:0] src_col,
	output logic                      is_padding,
	output logic [ADDR_W-1:0]         src_addr,
	output logic [ADDR_W-1:0]         dst_addr,
	output logic [TAP_W-1:0]          tap_index,
	output logic                      last_tap
);

	cfg_t              cfg;
	logic              q_push, q_pop;
	pos_t              q_wr, q_rd;
	logic [QCNT_W-1:0] q_count;

	ipag_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// front: per-position bases, credit-checked against the queue
	ipag_front #(
		.KERNEL_H  (KERNEL_H),
		.KERNEL_W  (KERNEL_W),
		.CH_BLOCKS (CH_BLOCKS),
		.BLOCK     (BLOCK),
		.OUT_H     (OUT_H),
		.OUT_W     (OUT_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.batch_index (batch_index),
		.out_row     (out_row),
		.out_col     (out_col),
		.q_count     (q_count),
		.q_push      (q_push),
		.q_data      (q_wr)
	);

	ipag_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.pop     (q_pop),
		.rd_data (q_rd),
		.count   (q_count)
	);

	// back: walks the taps incrementally, one per cycle unless the receiver stalls
	ipag_back #(
		.KERNEL_H  (KERNEL_H),
		.KERNEL_W  (KERNEL_W),
		.CH_BLOCKS (CH_BLOCKS),
		.BLOCK     (BLOCK),
		.OUT_H     (OUT_H),
		.OUT_W     (OUT_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_count    (q_count),
		.q_data     (q_rd),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.src_row    (src_row),
		.src_col    (src_col),
		.is_padding (is_padding),
		.src_addr   (src_addr),
		.dst_addr   (dst_addr),
		.tap_index  (tap_index),
		.last_tap   (last_tap)
	);

`ifndef SYNTHESIS
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && !q_pop && (q_count == QCNT_W'(QUEUE_DEPTH))))
		else $error("position queue overflow");

	a_queue_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_count != '0))
		else $error("pop from empty position queue");

	a_last_tap_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_tap) |-> (tap_index == TAP_W'(KERNEL_H * KERNEL_W - 1)))
		else $error("last_tap on wrong tap");

	a_pad_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_padding) |-> (src_addr == '0))
		else $error("padding tap with nonzero source address");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench;
	import ipag_pkg::*;

	// Block geometry; kept equal to the defaults of the generator.
	localparam int KERNEL_H  = 3;
	localparam int KERNEL_W  = 3;
	localparam int CH_BLOCKS = 8;
	localparam int BLOCK     = 8;
	localparam int OUT_H     = 64;
	localparam int OUT_W     = 64;
	localparam int TAPS      = KERNEL_H * KERNEL_W;

	localparam int PHASES    = 6;   // random register settings
	localparam int PER_PHASE = 50;  // positions per setting
	localparam int PLAN_LEN  = 50;  // rows in the directed table

	// One tap as it leaves the block.
	typedef struct {
		logic signed [COORD_W-1:0] src_row;
		logic signed [COORD_W-1:0] src_col;
		logic                      is_padding;
		logic [ADDR_W-1:0]         src_addr;
		logic [ADDR_W-1:0]         dst_addr;
		logic [TAP_W-1:0]          tap_index;
		logic                      last_tap;
	} tap_t;

	// Directed table: either a register write or a position. A position row may
	// carry hand-computed values for its first tap (row, col, pad, src, dst).
	typedef enum logic {STEP_WRITE, STEP_POSITION} step_kind_t;

	typedef struct packed {
		step_kind_t                kind;
		logic [REG_IDX_W-1:0]      reg_idx;
		logic [31:0]               value;
		logic [3:0]                b;
		logic [5:0]                r;
		logic [5:0]                c;
		logic                      golden;
		logic signed [COORD_W-1:0] g_row;
		logic signed [COORD_W-1:0] g_col;
		logic                      g_pad;
		logic [ADDR_W-1:0]         g_src;
		logic [ADDR_W-1:0]         g_dst;
	} step_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [PADDR_W-1:0]        paddr = '0;
	logic [PDATA_W-1:0]        pwdata = '0;
	logic [PDATA_W-1:0]        prdata;
	logic                      pready;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [3:0]                batch_index = '0;
	logic [5:0]                out_row = '0;
	logic [5:0]                out_col = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [COORD_W-1:0] src_row;
	logic signed [COORD_W-1:0] src_col;
	logic                      is_padding;
	logic [ADDR_W-1:0]         src_addr;
	logic [ADDR_W-1:0]         dst_addr;
	logic [TAP_W-1:0]          tap_index;
	logic                      last_tap;

	// Register values as the block should hold them; reset defaults here.
	cfg_t cfg_live = '{stride_rows: 5'd1, stride_cols: 5'd1, dilation_rows: 5'd1,
		dilation_cols: 5'd1, pad_top: 8'd0, pad_left: 8'd0, in_height: 13'd64,
		in_width: 13'd64};

	tap_t taps_due [$];         // taps predicted but not yet seen, oldest first
	int   mismatches = 0;
	int   positions_sent = 0;
	int   taps_seen = 0;
	int   pad_taps_seen = 0;
	int   reg_writes = 0;
	logic calm = 1'b0;          // no idling on either side once set

	image_patch_address_generator #(
		.KERNEL_H (KERNEL_H),
		.KERNEL_W (KERNEL_W),
		.CH_BLOCKS(CH_BLOCKS),
		.BLOCK    (BLOCK),
		.OUT_H    (OUT_H),
		.OUT_W    (OUT_W)
	) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Expected taps of one position under the current register values.
	// Everything is 32-bit unsigned, so addresses wrap just as the block's do.
	function automatic void predict_taps(input logic [3:0] b, input logic [5:0] orow,
			input logic [5:0] ocol);
		logic [31:0] chans;
		logic [31:0] plane;
		logic [31:0] src_base;
		logic [31:0] dst_base;
		logic [31:0] r_u;
		logic [31:0] c_u;
		int          r;
		int          c;
		int          n;
		tap_t        t;
		chans    = CH_BLOCKS * BLOCK;
		plane    = OUT_H * OUT_W;
		dst_base = b * TAPS * chans * plane + orow * OUT_W * BLOCK + ocol * BLOCK;
		src_base = b * chans * cfg_live.in_height * cfg_live.in_width;
		n = 0;
		for (int kh = 0; kh < KERNEL_H; kh++) begin
			r = int'(orow) * int'(cfg_live.stride_rows)
				+ kh * int'(cfg_live.dilation_rows) - int'(cfg_live.pad_top);
			for (int kw = 0; kw < KERNEL_W; kw++) begin
				c = int'(ocol) * int'(cfg_live.stride_cols)
					+ kw * int'(cfg_live.dilation_cols) - int'(cfg_live.pad_left);
				r_u = r;
				c_u = c;
				t.src_row    = r[COORD_W-1:0];
				t.src_col    = c[COORD_W-1:0];
				t.is_padding = r < 0 || r >= int'(cfg_live.in_height) ||
					c < 0 || c >= int'(cfg_live.in_width);
				t.src_addr   = t.is_padding ? '0 :
					src_base + r_u * cfg_live.in_width * BLOCK + c_u * BLOCK;
				t.dst_addr   = dst_base + n * chans * plane;
				t.tap_index  = n[TAP_W-1:0];
				t.last_tap   = (kh == KERNEL_H - 1) && (kw == KERNEL_W - 1);
				taps_due.push_back(t);
				n++;
			end
		end
	endfunction

	// APB write: setup phase, access phase, then an idle bus phase before returning.
	// pready is tied high.
	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// only the register's own width is kept
		case (idx)
			REG_STRIDE_ROWS:   cfg_live.stride_rows   = v[4:0];
			REG_STRIDE_COLS:   cfg_live.stride_cols   = v[4:0];
			REG_DILATION_ROWS: cfg_live.dilation_rows = v[4:0];
			REG_DILATION_COLS: cfg_live.dilation_cols = v[4:0];
			REG_PAD_TOP:       cfg_live.pad_top       = v[7:0];
			REG_PAD_LEFT:      cfg_live.pad_left      = v[7:0];
			REG_IN_HEIGHT:     cfg_live.in_height     = v[12:0];
			REG_IN_WIDTH:      cfg_live.in_width      = v[12:0];
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	// Hold valid high with the payload until the transfer, then predict.
	// Valid is left high so a following position can go out back to back.
	task automatic send_position(input logic [3:0] b, input logic [5:0] r,
			input logic [5:0] c);
		in_valid    <= 1'b1;
		batch_index <= b;
		out_row     <= r;
		out_col     <= c;
		do @(posedge clk); while (!in_ready);
		predict_taps(b, r, c);
		positions_sent++;
	endtask

	// Drop valid and wait until every predicted tap has come out. Always waits on
	// the clock first, so valid is never lowered and raised in one step.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (taps_due.size() != 0);
	endtask

	// Tap receiver: random stall bursts, broken up by quiet stretches
	// where every tap is taken at once.
	initial begin : tap_receiver
		int hold;
		int quiet;
		hold  = 0;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (calm || quiet > 0) begin
				if (quiet > 0)
					quiet--;
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 19) == 0) begin
				quiet = $urandom_range(20, 80);
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 4) == 0) begin
				hold = $urandom_range(1, 8) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Tap checker: each transfer against the oldest prediction, field by field.
	always @(posedge clk) begin : tap_checker
		tap_t want;
		if (arst_n && out_valid && out_ready) begin
			taps_seen++;
			if (is_padding)
				pad_taps_seen++;
			if (taps_due.size() == 0) begin
				$error("tap transfer with nothing pending: tap_index %0d", tap_index);
				mismatches++;
			end else begin
				want = taps_due.pop_front();
				if (src_row !== want.src_row) begin
					$error("src_row: expected %0d, got %0d", want.src_row, src_row);
					mismatches++;
				end
				if (src_col !== want.src_col) begin
					$error("src_col: expected %0d, got %0d", want.src_col, src_col);
					mismatches++;
				end
				if (is_padding !== want.is_padding) begin
					$error("is_padding: expected %0b, got %0b", want.is_padding, is_padding);
					mismatches++;
				end
				if (src_addr !== want.src_addr) begin
					$error("src_addr: expected 0x%08h, got 0x%08h", want.src_addr, src_addr);
					mismatches++;
				end
				if (dst_addr !== want.dst_addr) begin
					$error("dst_addr: expected 0x%08h, got 0x%08h", want.dst_addr, dst_addr);
					mismatches++;
				end
				if (tap_index !== want.tap_index) begin
					$error("tap_index: expected %0d, got %0d", want.tap_index, tap_index);
					mismatches++;
				end
				if (last_tap !== want.last_tap) begin
					$error("last_tap: expected %0b, got %0b", want.last_tap, last_tap);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		step_t       plan [PLAN_LEN];
		int          first;
		int          sel;
		int          w;
		logic [31:0] v;
		plan = '{
			// reset values: origin and far corner, hand-computed first tap
			'{STEP_POSITION, REG_STRIDE_ROWS, '0, 4'd0, 6'd0, 6'd0,
				1'b1, 14'sd0, 14'sd0, 1'b0, 32'd0, 32'd0},
			'{STEP_POSITION, REG_STRIDE_ROWS, '0, 4'd15, 6'd63, 6'd63,
				1'b1, 14'sd63, 14'sd63, 1'b0, 32'd3964920, 32'd35422200},
			'{STEP_POSITION, REG_STRIDE_ROWS, '0, 4'd10, 6'd21, 6'd42,
				1'b0, '0, '0, '0, '0, '0},
			'{STEP_POSITION, REG_STRIDE_ROWS, '0, 4'd5, 6'd42, 6'd21,
				1'b0, '0, '0, '0, '0, '0},
			// top of range: stride and dilation 16, 4096 x 4096 image
			'{STEP_WRITE, REG_STRIDE_ROWS, 32'd16, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_STRIDE_COLS, 32'd16, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_DILATION_ROWS, 32'd16, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_DILATION_COLS, 32'd16, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_IN_HEIGHT, 32'd4096, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_IN_WIDTH, 32'd4096, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_POSITION, REG_STRIDE_ROWS, '0, 4'd15, 6'd63, 6'd63,
				1'b0, '0, '0, '0, '0, '0},
			'{STEP_POSITION, REG_STRIDE_ROWS, '0, 4'd0, 6'd0, 6'd0,
				1'b0, '0, '0, '0, '0, '0},
			// zero stride and dilation: all nine taps land on one pixel
			'{STEP_WRITE, REG_STRIDE_ROWS, 32'd0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_STRIDE_COLS, 32'd0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_DILATION_ROWS, 32'd0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_DILATION_COLS, 32'd0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_POSITION, REG_STRIDE_ROWS, '0, 4'd7, 6'd33, 6'd12,
				1'b0, '0, '0, '0, '0, '0},
			'{STEP_POSITION, REG_STRIDE_ROWS, '0, 4'd8, 6'd0, 6'd63,
				1'b0, '0, '0, '0, '0, '0},
			// full register width, past the nominal range; source address wraps
			'{STEP_WRITE, REG_STRIDE_ROWS, 32'd31, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_STRIDE_COLS, 32'd31, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_DILATION_ROWS, 32'd31, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_DILATION_COLS, 32'd31, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_IN_HEIGHT, 32'd8191, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_IN_WIDTH, 32'd8191, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_POSITION, REG_STRIDE_ROWS, '0, 4'd15, 6'd63, 6'd63,
				1'b0, '0, '0, '0, '0, '0},
			'{STEP_POSITION, REG_STRIDE_ROWS, '0, 4'd1, 6'd1, 6'd1,
				1'b0, '0, '0, '0, '0, '0},
			// maximum padding: coordinates go negative, every tap padded
			'{STEP_WRITE, REG_STRIDE_ROWS, 32'd1, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_STRIDE_COLS, 32'd1, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_DILATION_ROWS, 32'd1, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_DILATION_COLS, 32'd1, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_IN_HEIGHT, 32'd64, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_IN_WIDTH, 32'd64, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_PAD_TOP, 32'd255, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_PAD_LEFT, 32'd255, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_POSITION, REG_STRIDE_ROWS, '0, 4'd0, 6'd0, 6'd0,
				1'b1, -14'sd255, -14'sd255, 1'b1, 32'd0, 32'd0},
			'{STEP_POSITION, REG_STRIDE_ROWS, '0, 4'd6, 6'd63, 6'd63,
				1'b0, '0, '0, '0, '0, '0},
			// 1 x 1 image with a one-pixel border: only one tap is real
			'{STEP_WRITE, REG_PAD_TOP, 32'd1, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_PAD_LEFT, 32'd1, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_IN_HEIGHT, 32'd1, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_IN_WIDTH, 32'd1, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_POSITION, REG_STRIDE_ROWS, '0, 4'd2, 6'd0, 6'd0,
				1'b0, '0, '0, '0, '0, '0},
			'{STEP_POSITION, REG_STRIDE_ROWS, '0, 4'd2, 6'd1, 6'd1,
				1'b0, '0, '0, '0, '0, '0},
			// zero height, then zero width: nothing but padding
			'{STEP_WRITE, REG_PAD_TOP, 32'd0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_PAD_LEFT, 32'd0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_IN_HEIGHT, 32'd0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_POSITION, REG_STRIDE_ROWS, '0, 4'd3, 6'd5, 6'd7,
				1'b1, 14'sd5, 14'sd7, 1'b1, 32'd0, 32'd7080504},
			'{STEP_POSITION, REG_STRIDE_ROWS, '0, 4'd9, 6'd60, 6'd3,
				1'b0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_IN_HEIGHT, 32'd64, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_WRITE, REG_IN_WIDTH, 32'd0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
			'{STEP_POSITION, REG_STRIDE_ROWS, '0, 4'd4, 6'd2, 6'd2,
				1'b0, '0, '0, '0, '0, '0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Writes only happen once the block has drained.
		foreach (plan[i]) begin
			if (plan[i].kind == STEP_WRITE) begin
				wait_idle();
				apb_write(plan[i].reg_idx, plan[i].value);
			end else begin
				send_position(plan[i].b, plan[i].r, plan[i].c);
				if (plan[i].golden) begin
					// first tap of this position: the hand-computed values rule
					first = taps_due.size() - TAPS;
					taps_due[first].src_row    = plan[i].g_row;
					taps_due[first].src_col    = plan[i].g_col;
					taps_due[first].is_padding = plan[i].g_pad;
					taps_due[first].src_addr   = plan[i].g_src;
					taps_due[first].dst_addr   = plan[i].g_dst;
				end
			end
		end

		// Random part: each phase drains, loads a fresh register set (extremes,
		// out-of-range values, junk in the unused upper bits) and streams
		// positions with random sender gaps. The last phase runs flat out.
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			for (int idx = 0; idx < 8; idx++) begin
				sel = $urandom_range(0, 9);
				case (idx[REG_IDX_W-1:0])
					REG_STRIDE_ROWS, REG_STRIDE_COLS, REG_DILATION_ROWS,
					REG_DILATION_COLS: begin
						w = 5;
						case (sel)
							0:       v = 1;
							1:       v = 16;
							2:       v = $urandom_range(0, 31);
							default: v = $urandom_range(1, 4);
						endcase
					end
					REG_PAD_TOP, REG_PAD_LEFT: begin
						w = 8;
						if (sel < 4)
							v = 0;
						else if (sel == 4)
							v = 255;
						else
							v = $urandom_range(0, 24);
					end
					default: begin
						w = 13;
						case (sel)
							0:       v = 1;
							1:       v = 4096;
							2:       v = $urandom_range(0, 8191);
							3, 4, 5: v = $urandom_range(1, 80);
							default: v = $urandom_range(1, 4096);
						endcase
					end
				endcase
				if ($urandom_range(0, 1) == 1)
					v = v | ($urandom() << w);
				apb_write(idx[REG_IDX_W-1:0], v);
			end
			if (ph == PHASES - 1)
				calm = 1'b1;
			for (int k = 0; k < PER_PHASE; k++) begin
				if (!calm && $urandom_range(0, 3) == 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
				send_position(4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
					6'($urandom_range(0, 63)));
			end
		end

		// Drain, then keep the clock running to catch any stray tap.
		wait_idle();
		repeat (20) @(posedge clk);

		$display("Checked %0d positions as %0d taps (%0d padding) over %0d register writes.",
			positions_sent, taps_seen, pad_taps_seen, reg_writes);
		$display("Settings covered zero/max stride and dilation, max padding, empty images.");
		if (mismatches == 0 && taps_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d taps never seen", mismatches, taps_due.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run (every tap stalled by the longest burst).
	initial begin : watchdog
		#5000000;
		$display("watchdog expired with %0d taps outstanding", taps_due.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ipag_pkg.sv
rtl/ipag_cfg_regs.sv
rtl/ipag_front.sv
rtl/ipag_queue.sv
rtl/ipag_back.sv
rtl/image_patch_address_generator.sv
tb/testbench.sv
